// ===== hw/rtl/lcd4_pkg.sv =====
// ----------------------------------------------------------------------------
// lcd4_pkg
// Shared constants for the character display 4-bit write sequencer.
// ----------------------------------------------------------------------------
package lcd4_pkg;

    localparam int LINE_COLUMNS_DEF = 40;
    localparam int SETTLE_MS_DEF    = 5;

    localparam int NUM_WIDTH  = 32;
    localparam int NUM_DIGITS = 10;
    localparam int INIT_LEN   = 7;

    localparam logic [2:0] FUNC_CMD    = 3'd0;
    localparam logic [2:0] FUNC_CHAR   = 3'd1;
    localparam logic [2:0] FUNC_INT    = 3'd2;
    localparam logic [2:0] FUNC_CURSOR = 3'd3;
    localparam logic [2:0] FUNC_INIT   = 3'd4;
    localparam logic [2:0] FUNC_CLEAR  = 3'd5;

    localparam logic [1:0] CELL_HOLD   = 2'd0;
    localparam logic [1:0] CELL_CLEAR  = 2'd1;
    localparam logic [1:0] CELL_DABBLE = 2'd2;
    localparam logic [1:0] CELL_SHIFT  = 2'd3;

    localparam logic [7:0] CMD_CLEAR   = 8'h01;
    localparam logic [7:0] LINE0_BASE  = 8'h80;
    localparam logic [7:0] LINE1_BASE  = 8'hC0;
    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;

    localparam logic [7:0] INIT_CMDS [INIT_LEN] =
        '{8'h33, 8'h32, 8'h28, 8'h0C, 8'h01, 8'h06, 8'h02};

    typedef struct packed {
        logic [1:0] op;
    } cell_ctl_t;

endpackage

// ===== hw/rtl/lcd4_bcd_cell.sv =====
// ----------------------------------------------------------------------------
// lcd4_bcd_cell
// One decimal digit of the conversion chain: clear, shift-add-3 step, or a digit
// move from the lower neighbor while leading zeros are skipped and the number is printed.
// ----------------------------------------------------------------------------
module lcd4_bcd_cell
    import lcd4_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctl_t  ctl,
    input  logic       bit_in,
    input  logic [3:0] digit_in,
    output logic       bit_out,
    output logic [3:0] digit
);

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] adj;

    assign adj     = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
    assign bit_out = adj[3];
    assign digit   = digit_reg;

    always_comb
    begin
        digit_next = digit_reg;
        case (ctl.op)
            CELL_CLEAR:  digit_next = 4'd0;
            CELL_DABBLE: digit_next = {adj[2:0], bit_in};
            CELL_SHIFT:  digit_next = digit_in;
            default:     digit_next = digit_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= 4'd0;
        end
        else
        begin
            digit_reg <= digit_next;
        end
    end

endmodule

// ===== hw/rtl/char_lcd_4bit_write_sequencer.sv =====
// ----------------------------------------------------------------------------
// char_lcd_4bit_write_sequencer
// Turns one request into the enable strobes of a 4-bit character display bus.
// ----------------------------------------------------------------------------
// Sequence: an accepted request goes to emission, or for an integer first
//   through bit-serial conversion in the decimal cell chain and a skip of
//   leading zeros. Throughput: one strobe per cycle while emitting; strobes
//   cannot be stalled, and busy blocks a new request until the last strobe.
// Reset: asynchronous, clears the sequencer to idle with no strobe pending.
module char_lcd_4bit_write_sequencer
    import lcd4_pkg::*;
#(
    parameter int LINE_COLUMNS = LINE_COLUMNS_DEF,
    parameter int SETTLE_MS    = SETTLE_MS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  func,
    input  logic [7:0]  byte_value,
    input  logic signed [31:0] number,
    input  logic        row,
    input  logic [5:0]  column,
    output logic        strobe,
    output logic        reg_select,
    output logic [3:0]  nibble,
    output logic [3:0]  wait_ms,
    output logic        last
);

    localparam logic [3:0] WAIT_BYTE = 4'((SETTLE_MS > 15) ? 15 : SETTLE_MS);
    localparam logic [3:0] WAIT_REQ  = 4'((2 * SETTLE_MS > 15) ? 15 : 2 * SETTLE_MS);
    localparam logic [5:0] COL_MAX   = 6'(LINE_COLUMNS - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SKIP = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [2:0]  func_reg, func_next;
    logic [7:0]  byte_reg, byte_next;
    logic        neg_reg, neg_next;
    logic [31:0] mag_reg, mag_next;
    logic [4:0]  bit_cnt_reg, bit_cnt_next;
    logic [3:0]  dig_left_reg, dig_left_next;
    logic [2:0]  idx_reg, idx_next;
    logic        half_reg, half_next;

    logic        strobe_reg, strobe_next;
    logic        rs_reg, rs_next;
    logic [3:0]  nib_reg, nib_next;
    logic [3:0]  wait_reg, wait_next;
    logic        last_reg, last_next;

    cell_ctl_t   cell_ctl;
    logic [NUM_DIGITS-1:0] cell_bit;
    logic [3:0]  cell_digit [NUM_DIGITS];

    logic        accept;
    logic [5:0]  col_sat;
    logic [7:0]  cursor_byte;
    logic [7:0]  cur_byte;
    logic        cur_rs;
    logic        cur_final;
    logic [3:0]  end_wait;

    genvar g;
    generate
        for (g = 0; g < NUM_DIGITS; g++)
        begin : g_cell
            lcd4_bcd_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (cell_ctl),
                .bit_in   ((g == 0) ? mag_reg[NUM_WIDTH-1] : cell_bit[(g == 0) ? 0 : g-1]),
                .digit_in ((g == 0) ? 4'd0 : cell_digit[(g == 0) ? 0 : g-1]),
                .bit_out  (cell_bit[g]),
                .digit    (cell_digit[g])
            );
        end
    endgenerate

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    assign col_sat     = ({1'b0, column} >= 7'(LINE_COLUMNS)) ? COL_MAX : column;
    assign cursor_byte = (row ? LINE1_BASE : LINE0_BASE) + {2'b00, col_sat};

    always_comb
    begin
        cur_byte  = byte_reg;
        cur_rs    = 1'b0;
        cur_final = 1'b1;
        end_wait  = WAIT_REQ;
        unique case (func_reg)
            FUNC_CMD:
            begin
                end_wait = WAIT_BYTE;
            end
            FUNC_CHAR:
            begin
                cur_rs   = 1'b1;
                end_wait = WAIT_BYTE;
            end
            FUNC_INT:
            begin
                cur_rs    = 1'b1;
                cur_byte  = neg_reg ? ASCII_MINUS
                                    : ASCII_ZERO + {4'd0, cell_digit[NUM_DIGITS-1]};
                cur_final = !neg_reg && (dig_left_reg == 4'd1);
            end
            FUNC_INIT:
            begin
                cur_byte  = INIT_CMDS[idx_reg];
                cur_final = (idx_reg == 3'(INIT_LEN - 1));
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        func_next     = func_reg;
        byte_next     = byte_reg;
        neg_next      = neg_reg;
        mag_next      = mag_reg;
        bit_cnt_next  = bit_cnt_reg;
        dig_left_next = dig_left_reg;
        idx_next      = idx_reg;
        half_next     = half_reg;
        cell_ctl.op   = CELL_HOLD;
        strobe_next   = 1'b0;
        rs_next       = rs_reg;
        nib_next      = nib_reg;
        wait_next     = wait_reg;
        last_next     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    func_next     = func;
                    idx_next      = 3'd0;
                    half_next     = 1'b0;
                    bit_cnt_next  = 5'd0;
                    dig_left_next = 4'(NUM_DIGITS);
                    neg_next      = number[31];
                    mag_next      = number[31] ? 32'd0 - $unsigned(number) : $unsigned(number);
                    case (func) inside
                        FUNC_CMD, FUNC_CHAR: byte_next = byte_value;
                        FUNC_CURSOR:         byte_next = cursor_byte;
                        default:             byte_next = CMD_CLEAR;
                    endcase
                    case (func) inside
                        FUNC_INT:
                        begin
                            cell_ctl.op = CELL_CLEAR;
                            state_next  = ST_CONV;
                        end
                        FUNC_CMD, FUNC_CHAR, FUNC_CURSOR, FUNC_INIT, FUNC_CLEAR:
                        begin
                            state_next = ST_EMIT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CONV:
            begin
                cell_ctl.op  = CELL_DABBLE;
                mag_next     = {mag_reg[NUM_WIDTH-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + 5'd1;
                if (bit_cnt_reg == 5'(NUM_WIDTH - 1))
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if ((cell_digit[NUM_DIGITS-1] == 4'd0) && (dig_left_reg > 4'd1))
                begin
                    cell_ctl.op   = CELL_SHIFT;
                    dig_left_next = dig_left_reg - 4'd1;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                strobe_next = 1'b1;
                rs_next     = cur_rs;
                nib_next    = half_reg ? cur_byte[3:0] : cur_byte[7:4];
                wait_next   = half_reg ? (cur_final ? end_wait : WAIT_BYTE) : 4'd0;
                last_next   = half_reg && cur_final;
                half_next   = !half_reg;
                if (half_reg)
                begin
                    if (cur_final)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (func_reg == FUNC_INT)
                    begin
                        if (neg_reg)
                        begin
                            neg_next = 1'b0;
                        end
                        else
                        begin
                            cell_ctl.op   = CELL_SHIFT;
                            dig_left_next = dig_left_reg - 4'd1;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        byte_reg     <= byte_next;
        neg_reg      <= neg_next;
        mag_reg      <= mag_next;
        bit_cnt_reg  <= bit_cnt_next;
        dig_left_reg <= dig_left_next;
        idx_reg      <= idx_next;
        half_reg     <= half_next;
        rs_reg       <= rs_next;
        nib_reg      <= nib_next;
        wait_reg     <= wait_next;
    end

    assign strobe     = strobe_reg;
    assign reg_select = rs_reg;
    assign nibble     = nib_reg;
    assign wait_ms    = wait_reg;
    assign last       = last_reg;

    a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> strobe && last)
        else $error("busy dropped without a final strobe");

    a_last_waits: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |-> wait_ms != 4'd0)
        else $error("final strobe without settle time");

    a_high_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (wait_ms == 4'd0) |-> !last)
        else $error("high nibble marked as final strobe");

    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |-> busy)
        else $error("strobe outside a request");

endmodule
